FILE: hw/rtl/caf_pkg.sv
// shared constants and types for the cell area fraction block
package caf_pkg;

    localparam int AREA_BITS = 16;
    localparam int COORD_W   = AREA_BITS + 1;
    localparam int N_SLOTS   = 8;
    localparam int N_EDGES   = 4;
    localparam int PROD_W    = 2 * COORD_W;
    localparam int DIFF_W    = PROD_W + 2;
    localparam int SUM_W     = DIFF_W + 3;

    typedef logic [COORD_W-1:0] coord_t;

    localparam coord_t AREA_ONE  = coord_t'(1) << AREA_BITS;
    localparam coord_t COORD_ZRO = '0;

endpackage

FILE: hw/rtl/cell_area_fraction_top.sv
// cell_area_fraction_top: pipelined negative-area fraction of one unit grid cell
// stages in order: stage 0, divider, slots fa and fb, shoelace pc to pg, output
// throughput: one word per cycle; busy stays low; the depth comes mostly from the 17
// one-bit restoring divider stages on each of the four cell edges
// reset: rst_n clears all valid bits asynchronously; the receiver cannot stall
module cell_area_fraction_top
    import caf_pkg::*;
#(
    parameter int VALUE_BITS = 32
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [VALUE_BITS-1:0] phi_x0_y0,
    input  logic signed [VALUE_BITS-1:0] phi_x1_y0,
    input  logic signed [VALUE_BITS-1:0] phi_x0_y1,
    input  logic signed [VALUE_BITS-1:0] phi_x1_y1,
    output logic                         done,
    output logic [COORD_W-1:0]           area_fraction
);

    localparam int MAG_W   = VALUE_BITS;
    localparam int DEN_W   = VALUE_BITS + 1;
    localparam int REM_W   = VALUE_BITS + 2;
    localparam int DIV_STG = AREA_BITS + 1;
    localparam int LATENCY = DIV_STG + 9;
    localparam int SHR     = AREA_BITS + 1;

    // stage 0: sign and magnitude of each corner
    logic                  s0_vld_reg;
    logic [3:0]            s0_neg_reg;
    logic [MAG_W-1:0]      s0_mag_reg [4];
    logic [3:0]            s0_neg_next;
    logic [MAG_W-1:0]      s0_mag_next [4];

    // divider stages, one quotient bit each
    logic                  dv_vld_reg [DIV_STG];
    logic [3:0]            dv_neg_reg [DIV_STG];
    logic [REM_W-1:0]      dv_rem_reg [DIV_STG][N_EDGES];
    logic [DEN_W-1:0]      dv_den_reg [DIV_STG][N_EDGES];
    logic [COORD_W-1:0]    dv_q_reg   [DIV_STG][N_EDGES];
    logic [REM_W-1:0]      dv_rem_next [DIV_STG][N_EDGES];
    logic [DEN_W-1:0]      dv_den_next [DIV_STG][N_EDGES];
    logic [COORD_W-1:0]    dv_q_next   [DIV_STG][N_EDGES];

    // polygon slots
    logic                  fa_vld_reg, fb_vld_reg;
    logic                  fa_none_reg, fb_none_reg;
    coord_t                fa_x_reg [N_SLOTS];
    coord_t                fa_y_reg [N_SLOTS];
    logic [N_SLOTS-1:0]    fa_pres_reg;
    coord_t                fa_ix_reg, fa_iy_reg;
    coord_t                fa_x_next [N_SLOTS];
    coord_t                fa_y_next [N_SLOTS];
    logic [N_SLOTS-1:0]    fa_pres_next;
    coord_t                fa_ix_next, fa_iy_next;
    coord_t                fb_x_reg [N_SLOTS];
    coord_t                fb_y_reg [N_SLOTS];
    coord_t                fb_x_next [N_SLOTS];
    coord_t                fb_y_next [N_SLOTS];

    // shoelace
    logic                  pc_vld_reg, pd_vld_reg, pe_vld_reg, pf_vld_reg, pg_vld_reg;
    logic                  pc_none_reg, pd_none_reg, pe_none_reg, pf_none_reg, pg_none_reg;
    logic [PROD_W-1:0]     pc_a_reg [N_SLOTS];
    logic [PROD_W-1:0]     pc_b_reg [N_SLOTS];
    logic signed [DIFF_W-1:0] pd_reg [N_SLOTS];
    logic signed [SUM_W-1:0]  pe_reg [4];
    logic signed [SUM_W-1:0]  pf_reg [2];
    logic signed [SUM_W-1:0]  pg_reg;

    logic                  out_vld_reg;
    logic [COORD_W-1:0]    out_area_reg;
    logic [COORD_W-1:0]    out_area_next;

    assign busy          = 1'b0;
    assign done          = out_vld_reg;
    assign area_fraction = out_area_reg;

    always_comb
    begin
        s0_neg_next = {phi_x1_y1[VALUE_BITS-1], phi_x0_y1[VALUE_BITS-1],
                       phi_x1_y0[VALUE_BITS-1], phi_x0_y0[VALUE_BITS-1]};
        s0_mag_next[0] = phi_x0_y0[VALUE_BITS-1] ? MAG_W'(-phi_x0_y0) : MAG_W'(phi_x0_y0);
        s0_mag_next[1] = phi_x1_y0[VALUE_BITS-1] ? MAG_W'(-phi_x1_y0) : MAG_W'(phi_x1_y0);
        s0_mag_next[2] = phi_x0_y1[VALUE_BITS-1] ? MAG_W'(-phi_x0_y1) : MAG_W'(phi_x0_y1);
        s0_mag_next[3] = phi_x1_y1[VALUE_BITS-1] ? MAG_W'(-phi_x1_y1) : MAG_W'(phi_x1_y1);
    end

    // edge e: crossing measured from corner ea toward corner eb
    function automatic logic [1:0] edge_a(input int e);
        logic [1:0] r;
        case (e)
            0:       r = 2'd0;
            1:       r = 2'd1;
            2:       r = 2'd2;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] edge_b(input int e);
        logic [1:0] r;
        case (e)
            0:       r = 2'd1;
            1:       r = 2'd3;
            2:       r = 2'd3;
            default: r = 2'd2;
        endcase
        return r;
    endfunction

    always_comb
    begin
        logic [REM_W-1:0] r;
        for (int e = 0; e < N_EDGES; e++)
        begin
            // the numerator never exceeds the divisor, so the top bit starts unshifted
            r = REM_W'(s0_mag_reg[edge_a(e)]);
            dv_den_next[0][e] = DEN_W'(s0_mag_reg[edge_a(e)]) + DEN_W'(s0_mag_reg[edge_b(e)]);
            if (r >= REM_W'(dv_den_next[0][e]))
            begin
                dv_rem_next[0][e] = r - REM_W'(dv_den_next[0][e]);
                dv_q_next[0][e]   = COORD_W'(1);
            end
            else
            begin
                dv_rem_next[0][e] = r;
                dv_q_next[0][e]   = '0;
            end
            for (int k = 1; k < DIV_STG; k++)
            begin
                r = dv_rem_reg[k-1][e] << 1;
                dv_den_next[k][e] = dv_den_reg[k-1][e];
                if (r >= REM_W'(dv_den_reg[k-1][e]))
                begin
                    dv_rem_next[k][e] = r - REM_W'(dv_den_reg[k-1][e]);
                    dv_q_next[k][e]   = {dv_q_reg[k-1][e][COORD_W-2:0], 1'b1};
                end
                else
                begin
                    dv_rem_next[k][e] = r;
                    dv_q_next[k][e]   = {dv_q_reg[k-1][e][COORD_W-2:0], 1'b0};
                end
            end
        end
    end

    // counterclockwise slots: corner, crossing, corner, crossing ...
    always_comb
    begin
        logic [3:0] n;
        n = dv_neg_reg[DIV_STG-1];
        fa_x_next[0] = COORD_ZRO;                   fa_y_next[0] = COORD_ZRO;
        fa_x_next[1] = dv_q_reg[DIV_STG-1][0];      fa_y_next[1] = COORD_ZRO;
        fa_x_next[2] = AREA_ONE;                    fa_y_next[2] = COORD_ZRO;
        fa_x_next[3] = AREA_ONE;                    fa_y_next[3] = dv_q_reg[DIV_STG-1][1];
        fa_x_next[4] = AREA_ONE;                    fa_y_next[4] = AREA_ONE;
        fa_x_next[5] = dv_q_reg[DIV_STG-1][2];      fa_y_next[5] = AREA_ONE;
        fa_x_next[6] = COORD_ZRO;                   fa_y_next[6] = AREA_ONE;
        fa_x_next[7] = COORD_ZRO;                   fa_y_next[7] = dv_q_reg[DIV_STG-1][3];
        fa_pres_next = {n[2] ^ n[0], n[2], n[3] ^ n[2], n[3],
                        n[1] ^ n[3], n[1], n[0] ^ n[1], n[0]};
        // last present slot, for the wrap-around of the duplicate fill
        fa_ix_next = COORD_ZRO;
        fa_iy_next = COORD_ZRO;
        for (int i = 0; i < N_SLOTS; i++)
        begin
            if (fa_pres_next[i])
            begin
                fa_ix_next = fa_x_next[i];
                fa_iy_next = fa_y_next[i];
            end
        end
    end

    // absent slots repeat the previous vertex and add nothing to the sum
    always_comb
    begin
        coord_t lx, ly;
        lx = fa_ix_reg;
        ly = fa_iy_reg;
        for (int i = 0; i < N_SLOTS; i++)
        begin
            if (fa_pres_reg[i])
            begin
                lx = fa_x_reg[i];
                ly = fa_y_reg[i];
            end
            fb_x_next[i] = lx;
            fb_y_next[i] = ly;
        end
    end

    always_comb
    begin
        logic [SUM_W:0]   mag;
        logic [SUM_W:0]   rnd;
        mag = pg_reg[SUM_W-1] ? (SUM_W+1)'(-pg_reg) : (SUM_W+1)'(pg_reg);
        rnd = (mag + ((SUM_W+1)'(1) << AREA_BITS)) >> SHR;
        if (pg_none_reg)
            out_area_next = '0;
        else if (rnd > (SUM_W+1)'(AREA_ONE))
            out_area_next = AREA_ONE;
        else
            out_area_next = rnd[COORD_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg  <= 1'b0;
            for (int k = 0; k < DIV_STG; k++)
            begin
                dv_vld_reg[k] <= 1'b0;
            end
            fa_vld_reg  <= 1'b0;
            fb_vld_reg  <= 1'b0;
            pc_vld_reg  <= 1'b0;
            pd_vld_reg  <= 1'b0;
            pe_vld_reg  <= 1'b0;
            pf_vld_reg  <= 1'b0;
            pg_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            s0_vld_reg    <= start && !busy;
            dv_vld_reg[0] <= s0_vld_reg;
            for (int k = 1; k < DIV_STG; k++)
            begin
                dv_vld_reg[k] <= dv_vld_reg[k-1];
            end
            fa_vld_reg  <= dv_vld_reg[DIV_STG-1];
            fb_vld_reg  <= fa_vld_reg;
            pc_vld_reg  <= fb_vld_reg;
            pd_vld_reg  <= pc_vld_reg;
            pe_vld_reg  <= pd_vld_reg;
            pf_vld_reg  <= pe_vld_reg;
            pg_vld_reg  <= pf_vld_reg;
            out_vld_reg <= pg_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s0_neg_reg <= s0_neg_next;
        for (int c = 0; c < 4; c++)
        begin
            s0_mag_reg[c] <= s0_mag_next[c];
        end
        dv_neg_reg[0] <= s0_neg_reg;
        for (int k = 1; k < DIV_STG; k++)
        begin
            dv_neg_reg[k] <= dv_neg_reg[k-1];
        end
        for (int k = 0; k < DIV_STG; k++)
        begin
            for (int e = 0; e < N_EDGES; e++)
            begin
                dv_rem_reg[k][e] <= dv_rem_next[k][e];
                dv_den_reg[k][e] <= dv_den_next[k][e];
                dv_q_reg[k][e]   <= dv_q_next[k][e];
            end
        end
        fa_none_reg <= (dv_neg_reg[DIV_STG-1] == 4'b0000);
        fa_pres_reg <= fa_pres_next;
        fa_ix_reg   <= fa_ix_next;
        fa_iy_reg   <= fa_iy_next;
        fb_none_reg <= fa_none_reg;
        pc_none_reg <= fb_none_reg;
        for (int i = 0; i < N_SLOTS; i++)
        begin
            fa_x_reg[i] <= fa_x_next[i];
            fa_y_reg[i] <= fa_y_next[i];
            fb_x_reg[i] <= fb_x_next[i];
            fb_y_reg[i] <= fb_y_next[i];
            pc_a_reg[i] <= PROD_W'(fb_x_reg[i]) * PROD_W'(fb_y_reg[(i + 1) % N_SLOTS]);
            pc_b_reg[i] <= PROD_W'(fb_x_reg[(i + 1) % N_SLOTS]) * PROD_W'(fb_y_reg[i]);
            pd_reg[i]   <= $signed({2'b00, pc_a_reg[i]}) - $signed({2'b00, pc_b_reg[i]});
        end
        pd_none_reg <= pc_none_reg;
        pe_none_reg <= pd_none_reg;
        for (int i = 0; i < 4; i++)
        begin
            pe_reg[i] <= SUM_W'(pd_reg[2*i]) + SUM_W'(pd_reg[2*i+1]);
        end
        pf_none_reg <= pe_none_reg;
        pf_reg[0]   <= pe_reg[0] + pe_reg[1];
        pf_reg[1]   <= pe_reg[2] + pe_reg[3];
        pg_none_reg <= pf_none_reg;
        pg_reg      <= pf_reg[0] + pf_reg[1];
        out_area_reg <= out_area_next;
    end

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("accepted word did not come out after the pipe latency");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> out_vld_reg && pg_vld_reg == $past(pf_vld_reg))
        else $error("valid chain out of step");

    a_saturate: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> area_fraction <= AREA_ONE)
        else $error("area fraction above one");

    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (pg_vld_reg && pg_none_reg) |=> (done && area_fraction == '0))
        else $error("cell with no negative corner gave nonzero area");

endmodule

FILE: tb/tb.sv
// testbench for the cell area fraction block: queued driver, predictor and monitor
module tb
    import caf_pkg::*;
();

    localparam int VB = 32;
    localparam int LATENCY = 26;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct {
        logic signed [VB-1:0] c00;
        logic signed [VB-1:0] c10;
        logic signed [VB-1:0] c01;
        logic signed [VB-1:0] c11;
    } cell_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [VB-1:0] phi_x0_y0 = '0;
    logic signed [VB-1:0] phi_x1_y0 = '0;
    logic signed [VB-1:0] phi_x0_y1 = '0;
    logic signed [VB-1:0] phi_x1_y1 = '0;
    logic done;
    logic [COORD_W-1:0] area_fraction;

    cell_t pending_cells[$];
    logic [COORD_W-1:0] expected_areas[$];
    int fail_count = 0;
    int idle_cycles = 0;
    int gap_left = 0;
    bit stim_done = 1'b0;

    cell_area_fraction_top #(.VALUE_BITS(VB)) dut (.*);

    always #5 clk = ~clk;

    // Q1.16 position of the zero crossing from a toward b
    function automatic longint cross_at(longint ma, longint mb);
        return (ma << AREA_BITS) / (ma + mb);
    endfunction

    function automatic logic [COORD_W-1:0] negative_area(cell_t c);
        longint mag[4];
        bit neg[4];
        longint xs[8], ys[8];
        longint s, twice, a, one;
        int n, j;
        one = longint'(1) << AREA_BITS;
        neg[0] = c.c00[VB-1]; mag[0] = neg[0] ? -longint'(c.c00) : longint'(c.c00);
        neg[1] = c.c10[VB-1]; mag[1] = neg[1] ? -longint'(c.c10) : longint'(c.c10);
        neg[2] = c.c01[VB-1]; mag[2] = neg[2] ? -longint'(c.c01) : longint'(c.c01);
        neg[3] = c.c11[VB-1]; mag[3] = neg[3] ? -longint'(c.c11) : longint'(c.c11);
        if (neg[0] && neg[1] && neg[2] && neg[3])
            return AREA_ONE;
        if (!neg[0] && !neg[1] && !neg[2] && !neg[3])
            return COORD_ZRO;
        n = 0;
        if (neg[0]) begin xs[n] = 0; ys[n] = 0; n++; end
        if (neg[0] != neg[1]) begin xs[n] = cross_at(mag[0], mag[1]); ys[n] = 0; n++; end
        if (neg[1]) begin xs[n] = one; ys[n] = 0; n++; end
        if (neg[1] != neg[3]) begin xs[n] = one; ys[n] = cross_at(mag[1], mag[3]); n++; end
        if (neg[3]) begin xs[n] = one; ys[n] = one; n++; end
        if (neg[3] != neg[2]) begin xs[n] = cross_at(mag[2], mag[3]); ys[n] = one; n++; end
        if (neg[2]) begin xs[n] = 0; ys[n] = one; n++; end
        if (neg[2] != neg[0]) begin xs[n] = 0; ys[n] = cross_at(mag[0], mag[2]); n++; end
        s = 0;
        for (int i = 0; i < n; i++) begin
            j = (i + 1 < n) ? i + 1 : 0;
            s += xs[i] * ys[j] - xs[j] * ys[i];
        end
        twice = s < 0 ? -s : s;
        a = (twice + one) >>> (AREA_BITS + 1);
        if (a > one)
            a = one;
        return a[COORD_W-1:0];
    endfunction

    function automatic logic signed [VB-1:0] rand_level();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return VB'($signed($urandom_range(0, 131072)) - 65536);
            2: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            3: return VB'($signed($urandom_range(0, 8)) - 4);
            default: return VB'($signed($urandom_range(0, 2000000)) - 1000000);
        endcase
    endfunction

    function automatic logic signed [VB-1:0] edge_val(int k);
        case (k)
            0: return 32'sh80000000;
            1: return 32'sh7fffffff;
            2: return 0;
            3: return -1;
            4: return 1;
            default: return -32'sd65536;
        endcase
    endfunction

    initial begin
        cell_t c;
        // corner extremes, zeros and saddles
        for (int i = 0; i < 24; i++) begin
            c.c00 = edge_val(i % 6);
            c.c10 = edge_val((i / 6 + i) % 6);
            c.c01 = edge_val((i * 5 + 1) % 6);
            c.c11 = edge_val((i * 7 + 3) % 6);
            pending_cells.insert(pending_cells.size(), c);
        end
        c = '{-32'sd65536, 32'sd65536, 32'sd65536, -32'sd65536};
        pending_cells.insert(pending_cells.size(), c);
        c = '{32'sd65536, -32'sd65536, -32'sd65536, 32'sd65536};
        pending_cells.insert(pending_cells.size(), c);
        for (int i = 0; i < 1350; i++) begin
            c.c00 = rand_level(); c.c10 = rand_level();
            c.c01 = rand_level(); c.c11 = rand_level();
            pending_cells.insert(pending_cells.size(), c);
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    // driver
    always @(posedge clk) begin
        if (rst_n) begin
            if (start && !busy) begin
                expected_areas.insert(expected_areas.size(),
                                      negative_area('{phi_x0_y0, phi_x1_y0,
                                                      phi_x0_y1, phi_x1_y1}));
                gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
                if ($urandom_range(0, 2) == 0)
                    gap_left = 0;
            end
            if (start && busy) begin
                // hold the word until taken
            end else if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end else if (pending_cells.size() > 0) begin
                cell_t c;
                c = pending_cells.pop_front();
                start <= 1'b1;
                phi_x0_y0 <= c.c00;
                phi_x1_y0 <= c.c10;
                phi_x0_y1 <= c.c01;
                phi_x1_y1 <= c.c11;
            end else begin
                start <= 1'b0;
                stim_done = 1'b1;
            end
        end
    end

    // monitor and watchdog
    always @(posedge clk) begin
        if (rst_n) begin
            idle_cycles++;
            if (start && !busy)
                idle_cycles = 0;
            if (done) begin
                idle_cycles = 0;
                if (expected_areas.size() == 0) begin
                    $error("area_fraction: unexpected word, actual %0d", area_fraction);
                    fail_count++;
                end else begin
                    logic [COORD_W-1:0] e;
                    e = expected_areas.pop_front();
                    if (area_fraction !== e) begin
                        $error("area_fraction: expected %0d actual %0d", e, area_fraction);
                        fail_count++;
                    end
                end
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    initial begin
        wait (stim_done && expected_areas.size() == 0);
        repeat (LATENCY + 4) @(posedge clk);
        if (fail_count == 0 && expected_areas.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
